// ===== sv/lisp_token_scanner_unit_assert.svh =====
// assertion macros for the s-expression token scanner
// expects i_clk and i_rst_n in the scope of use
`ifndef LISP_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define LISP_TOKEN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define LTS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// next-cycle implication
`define LTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

// ===== sv/lts_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and character classes for the s-expression token scanner
// no dependencies
package lts_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_SYMBOL  = 3'd4;
    localparam logic [2:0] MODE_SIGN    = 3'd5;

    localparam logic [2:0] KIND_DOT    = 3'd0;
    localparam logic [2:0] KIND_QUOTE  = 3'd1;
    localparam logic [2:0] KIND_LPAREN = 3'd2;
    localparam logic [2:0] KIND_RPAREN = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;
    localparam logic [2:0] KIND_SYMBOL = 3'd5;
    localparam logic [2:0] KIND_INT    = 3'd6;
    localparam logic [2:0] KIND_END    = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [31:0] value;
        logic        last;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic continues_symbol(input logic [7:0] c);
        return (c != CH_NUL) && !is_space(c) && !(c inside {CH_SEMI, CH_LPAREN, CH_RPAREN,
            CH_QUOTE});
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == LEN_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ===== sv/lisp_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// s-expression token scanner: byte stream in, token stream out
// depends on lts_pkg and lisp_token_scanner_unit_assert.svh
//
// usage
//   slave side takes one source byte per item on i_s_tdata; a zero byte gives an end token
//   master side gives one token per item: kind on o_m_tuser, offset, length and
//   integer value on o_m_tdata, o_m_tlast high on the final token caused by a byte
//   each accepted byte is scanned in the cycle it is taken; its tokens enter a
//   four-entry result queue and the first is offered on the next cycle if the queue was empty
//   throughput: one byte per cycle while o_s_tready is high; a byte that ends a token
//   and is itself a bracket, dot, quote or zero byte gives two tokens, which the queue absorbs
//   o_s_tready is high while at least two queue slots are free, so a stalled
//   receiver backs up the input after at most four pending tokens
//   reset (i_rst_n low, synchronous) empties the queue, sets the scanner to idle
//   and the byte offset to zero
module lisp_token_scanner_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [15:0] start_offset, [31:16] token_length, [63:32] int_value
    output logic [2:0]  o_m_tuser,   // [2:0] token_kind
    output logic        o_m_tlast    // last_of_run
);
    import lts_pkg::*;

    logic [2:0]               r_mode,      n_mode;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_tok_start, n_tok_start;
    logic [15:0]              r_len,       n_len;
    logic [31:0]              r_acc,       n_acc;
    logic                     r_neg,       n_neg;

    t_result                  r_fifo [FIFO_DEPTH];
    logic [PTR_BITS-1:0]      r_wr, r_rd;
    logic [CNT_BITS-1:0]      r_count;

    logic        accept, pop;
    logic [7:0]  c;
    logic [31:0] dval, acc_next;
    logic [15:0] pos16;
    logic        a_vld, b_vld, do_idle;
    t_result     res_a, res_b, slot0, slot1;
    logic [1:0]  n_push;

    assign c        = i_s_tdata;
    assign accept   = i_s_tvalid && o_s_tready;
    assign pop      = o_m_tvalid && i_m_tready;
    assign dval     = {24'd0, c - CH_ZERO};
    assign acc_next = (r_acc << 3) + (r_acc << 1) + dval;
    assign pos16    = 16'(r_pos);

    always_comb begin
        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_len       = r_len;
        n_acc       = r_acc;
        n_neg       = r_neg;
        a_vld       = 1'b0;
        b_vld       = 1'b0;
        do_idle     = 1'b0;
        res_a       = '0;
        res_b       = '0;

        case (r_mode)
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_NUL) do_idle = 1'b1;
            end
            MODE_STRING: begin
                if (c == CH_DQUOTE || c == CH_NUL) begin
                    a_vld        = 1'b1;
                    res_a.kind   = KIND_STRING;
                    res_a.start  = 16'(r_tok_start);
                    res_a.length = r_len;
                    n_mode       = MODE_IDLE;
                    do_idle      = (c == CH_NUL);
                end else begin
                    n_len = sat_inc(r_len);
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    n_acc = acc_next;
                end else begin
                    a_vld       = 1'b1;
                    res_a.kind  = KIND_INT;
                    res_a.start = 16'(r_tok_start);
                    res_a.value = r_neg ? (32'd0 - r_acc) : r_acc;
                    do_idle     = 1'b1;
                end
            end
            MODE_SIGN: begin
                if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    n_acc  = dval;
                end else if (continues_symbol(c)) begin
                    n_mode = MODE_SYMBOL;
                    n_len  = 16'd2;
                end else begin
                    a_vld        = 1'b1;
                    res_a.kind   = KIND_SYMBOL;
                    res_a.start  = 16'(r_tok_start);
                    res_a.length = 16'd1;
                    do_idle      = 1'b1;
                end
            end
            MODE_SYMBOL: begin
                if (continues_symbol(c)) begin
                    n_len = sat_inc(r_len);
                end else begin
                    a_vld        = 1'b1;
                    res_a.kind   = KIND_SYMBOL;
                    res_a.start  = 16'(r_tok_start);
                    res_a.length = r_len;
                    do_idle      = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // scan the byte as the start of what follows
        if (do_idle) begin
            n_mode      = MODE_IDLE;
            res_b.start = pos16;
            if (c == CH_NUL) begin
                b_vld      = 1'b1;
                res_b.kind = KIND_END;
            end else if (is_space(c)) begin
                n_mode = MODE_IDLE;
            end else if (c == CH_SEMI) begin
                n_mode = MODE_COMMENT;
            end else if (c == CH_DOT) begin
                b_vld      = 1'b1;
                res_b.kind = KIND_DOT;
            end else if (c == CH_QUOTE) begin
                b_vld      = 1'b1;
                res_b.kind = KIND_QUOTE;
            end else if (c == CH_LPAREN) begin
                b_vld      = 1'b1;
                res_b.kind = KIND_LPAREN;
            end else if (c == CH_RPAREN) begin
                b_vld      = 1'b1;
                res_b.kind = KIND_RPAREN;
            end else if (c == CH_DQUOTE) begin
                n_mode      = MODE_STRING;
                n_tok_start = r_pos;
                n_len       = 16'd0;
            end else if (is_digit(c)) begin
                n_mode      = MODE_NUMBER;
                n_tok_start = r_pos;
                n_acc       = dval;
                n_neg       = 1'b0;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                n_mode      = MODE_SIGN;
                n_tok_start = r_pos;
                n_acc       = 32'd0;
                n_neg       = (c == CH_MINUS);
            end else begin
                n_mode      = MODE_SYMBOL;
                n_tok_start = r_pos;
                n_len       = 16'd1;
            end
        end

        res_a.last = !b_vld;
        res_b.last = 1'b1;
        slot0      = a_vld ? res_a : res_b;
        slot1      = res_b;
        n_push     = {1'b0, a_vld} + {1'b0, b_vld};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_pos       <= '0;
            r_tok_start <= '0;
            r_len       <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_pos       <= r_pos + 1'b1;
            r_tok_start <= n_tok_start;
            r_len       <= n_len;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) r_wr <= r_wr + PTR_BITS'(n_push);
            if (pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (accept ? CNT_BITS'(n_push) : '0) - CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_push != 2'd0) r_fifo[r_wr] <= slot0;
        if (accept && n_push == 2'd2) r_fifo[r_wr + 1'b1] <= slot1;
    end

    assign o_s_tready = (r_count <= CNT_BITS'(FIFO_DEPTH - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {r_fifo[r_rd].value, r_fifo[r_rd].length, r_fifo[r_rd].start};
    assign o_m_tuser  = r_fifo[r_rd].kind;
    assign o_m_tlast  = r_fifo[r_rd].last;

`include "lisp_token_scanner_unit_assert.svh"

    `LTS_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CNT_BITS'(FIFO_DEPTH))
    `LTS_ASSERT_NEXT(a_count_step, 1'b1, r_count == $past(r_count) + (($past(accept)) ? CNT_BITS'($past(n_push)) : CNT_BITS'(0)) - CNT_BITS'($past(pop)))
    `LTS_ASSERT_IMPLY(a_pair_order, accept && n_push == 2'd2, !slot0.last && slot1.last)
    `LTS_ASSERT_NEXT(a_nul_to_idle, accept && c == CH_NUL, r_mode == MODE_IDLE)

endmodule

// ===== test/lisp_token_scanner_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lisp_token_scanner_unit: random and directed byte streams,
// a token predictor in a small scoreboard class and randomized stalls on both stream sides
// depends on lts_pkg and the scanner rtl
module lisp_token_scanner_unit_tb;
    import lts_pkg::*;

    class token_scoreboard;
        int          errors;
        t_result     pending_tokens[$];
        t_result     byte_tokens[$];
        logic [2:0]  scan_state;
        logic [15:0] next_offset;
        logic [15:0] tok_start;
        logic [15:0] body_len;
        logic [31:0] magnitude;
        logic        minus;

        function new();
            errors      = 0;
            scan_state  = MODE_IDLE;
            next_offset = '0;
            tok_start   = '0;
            body_len    = '0;
            magnitude   = '0;
            minus       = 1'b0;
        endfunction

        static function bit blank_char(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        static function bit digit_char(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        static function bit symbol_char(logic [7:0] c);
            return c != CH_NUL && !blank_char(c) && c != CH_SEMI && c != CH_LPAREN &&
                c != CH_RPAREN && c != CH_QUOTE;
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function logic [15:0] grow(logic [15:0] n);
            return (n == 16'hFFFF) ? n : n + 16'd1;
        endfunction

        function void add(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                          logic [31:0] value);
            t_result t;
            t.kind   = kind;
            t.start  = start;
            t.length = len;
            t.value  = value;
            t.last   = 1'b0;
            byte_tokens.push_back(t);
        endfunction

        function void from_idle(logic [7:0] c, logic [15:0] p);
            scan_state = MODE_IDLE;
            if (c == CH_NUL) begin
                add(KIND_END, p, '0, '0);
            end else if (blank_char(c)) begin
            end else if (c == CH_SEMI) begin
                scan_state = MODE_COMMENT;
            end else if (c == CH_DOT) begin
                add(KIND_DOT, p, '0, '0);
            end else if (c == CH_QUOTE) begin
                add(KIND_QUOTE, p, '0, '0);
            end else if (c == CH_LPAREN) begin
                add(KIND_LPAREN, p, '0, '0);
            end else if (c == CH_RPAREN) begin
                add(KIND_RPAREN, p, '0, '0);
            end else if (c == CH_DQUOTE) begin
                scan_state = MODE_STRING;
                tok_start  = p;
                body_len   = '0;
            end else if (digit_char(c)) begin
                scan_state = MODE_NUMBER;
                tok_start  = p;
                magnitude  = 32'(c - CH_ZERO);
                minus      = 1'b0;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                scan_state = MODE_SIGN;
                tok_start  = p;
                magnitude  = '0;
                minus      = (c == CH_MINUS);
            end else begin
                scan_state = MODE_SYMBOL;
                tok_start  = p;
                body_len   = 16'd1;
            end
        endfunction

        function void symbol_step(logic [7:0] c, logic [15:0] p);
            if (symbol_char(c)) begin
                body_len = grow(body_len);
            end else begin
                add(KIND_SYMBOL, tok_start, body_len, '0);
                from_idle(c, p);
            end
        endfunction

        function void note_byte(logic [7:0] c);
            logic [15:0] p;
            p = next_offset;
            byte_tokens.delete();
            case (scan_state)
                MODE_COMMENT: begin
                    if (c == CH_LF || c == CH_NUL) from_idle(c, p);
                end
                MODE_STRING: begin
                    if (c == CH_DQUOTE) begin
                        add(KIND_STRING, tok_start, body_len, '0);
                        scan_state = MODE_IDLE;
                    end else if (c == CH_NUL) begin
                        add(KIND_STRING, tok_start, body_len, '0);
                        from_idle(c, p);
                    end else begin
                        body_len = grow(body_len);
                    end
                end
                MODE_NUMBER: begin
                    if (digit_char(c)) begin
                        magnitude = magnitude * 32'd10 + 32'(c - CH_ZERO);
                    end else begin
                        add(KIND_INT, tok_start, '0, minus ? 32'd0 - magnitude : magnitude);
                        from_idle(c, p);
                    end
                end
                MODE_SIGN: begin
                    if (digit_char(c)) begin
                        scan_state = MODE_NUMBER;
                        magnitude  = 32'(c - CH_ZERO);
                    end else begin
                        scan_state = MODE_SYMBOL;
                        body_len   = 16'd1;
                        symbol_step(c, p);
                    end
                end
                MODE_SYMBOL: symbol_step(c, p);
                default: from_idle(c, p);
            endcase
            if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
            foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
            next_offset = p + 16'd1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_token(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                                  logic [31:0] value, logic last);
            t_result want;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d start %0h",
                    $time, kind, start);
                errors++;
                return;
            end
            want = pending_tokens.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(kind));
            compare_field("start_offset", 32'(want.start), 32'(start));
            compare_field("token_length", 32'(want.length), 32'(len));
            compare_field("int_value", want.value, value);
            compare_field("last_of_run", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    logic [7:0]  src[$];
    logic [15:0] rx_tick = '0;
    logic [1:0]  rx_mode = '0;

    token_scoreboard scanner_sb;

    lisp_token_scanner_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // receiver stall pattern, with a new random style chosen whenever rx_tick[6:0] is zero
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (rx_tick[3:0] < 4'd5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            scanner_sb.check_token(o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16],
                o_m_tdata[63:32], o_m_tlast);
    end

    task automatic send_byte(input logic [7:0] c);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        scanner_sb.note_byte(c);
    endtask

    task automatic pause(input int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_stream(input bit with_gaps);
        int burst;
        burst = $urandom_range(1, 24);
        foreach (src[i]) begin
            send_byte(src[i]);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if (with_gaps && $urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
            end
        end
        src.delete();
        pause(1);
    endtask

    task automatic wait_drain();
        while (scanner_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_byte_except(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] symbol_byte(bit first);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (!token_scoreboard::symbol_char(c) || (first && (token_scoreboard::digit_char(c)
            || c == CH_PLUS || c == CH_MINUS || c == CH_DQUOTE || c == CH_DOT)));
        return c;
    endfunction

    function automatic void add_random_token();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 3))
                src.push_back($urandom_range(0, 5) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
        end else if (pick < 20) begin
            src.push_back(CH_SEMI);
            repeat ($urandom_range(0, 8)) src.push_back(any_byte_except(CH_LF, CH_NUL));
            src.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_LF);
        end else if (pick < 30) begin
            src.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 10)) src.push_back(any_byte_except(CH_DQUOTE, CH_NUL));
            src.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_DQUOTE);
        end else if (pick < 50) begin
            n = $urandom_range(0, 2);
            if (n == 0) src.push_back(CH_PLUS);
            else if (n == 1) src.push_back(CH_MINUS);
            // long digit runs can wrap the value
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
            repeat (n) src.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick < 65) begin
            src.push_back(symbol_byte(1'b1));
            repeat ($urandom_range(0, 6)) src.push_back(symbol_byte(1'b0));
        end else if (pick < 70) begin
            src.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end else if (pick < 85) begin
            n = $urandom_range(0, 3);
            src.push_back(n == 0 ? CH_LPAREN : n == 1 ? CH_RPAREN : n == 2 ? CH_DOT : CH_QUOTE);
        end else if (pick < 90) begin
            src.push_back(CH_NUL);
        end else begin
            src.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) src.push_back(8'h20);
    endfunction

    initial begin
        scanner_sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sign then digit, sign then other byte, control and high bytes, unterminated
        // string, comment at end, bytes after end, empty string, wrapping integer
        src = '{CH_LPAREN, CH_PLUS, "1", CH_MINUS, 8'h01, CH_QUOTE, 8'hFF, CH_DOT, CH_RPAREN,
                CH_DQUOTE, "s", CH_NUL, CH_MINUS, "7", CH_SEMI, CH_NUL, CH_DQUOTE, CH_DQUOTE,
                "4", "2", "9", "4", "9", "6", "7", "2", "9", "7", CH_RPAREN};
        send_stream(1'b1);
        wait_drain();

        while (src.size() < 850) add_random_token();
        send_stream(1'b1);

        while (src.size() < 850) add_random_token();
        src.push_back(CH_NUL);
        send_stream(1'b1);

        wait_drain();
        repeat (16) @(posedge i_clk);
        if (scanner_sb.errors == 0 && scanner_sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/lts_pkg.sv
sv/lisp_token_scanner_unit.sv
test/lisp_token_scanner_unit_tb.sv
